// File: src/sacl_pkg.sv
`timescale 1ns / 1ps
// Shared geometry, entry layout and register codes of the cache tag controller.
package sacl_pkg;

  localparam int NUM_SETS    = 64;
  localparam int NUM_WAYS    = 4;
  localparam int BLOCK_BYTES = 32;

  localparam int ADDR_W  = 32;
  localparam int WORD_W  = 32;
  localparam int STAMP_W = 32;
  localparam int OFFS_W  = $clog2(BLOCK_BYTES);
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int TAG_W   = ADDR_W - OFFS_W - $clog2(NUM_SETS);
  localparam int WAY_W   = 2;

  // One way of a set row; valid bits live in flops outside the RAM.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } way_entry_t;

  typedef way_entry_t [NUM_WAYS-1:0] set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  // Result of the tag match and victim search over one set.
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim_way;
  } lookup_t;

  typedef enum logic {
    CFG_WRITE_ALLOCATE  = 1'b0,
    CFG_WRITE_BACK_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } ctrl_state_e;

endpackage

// File: src/sacl_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sacl_way_sel.sv
`timescale 1ns / 1ps
// Tag match and LRU victim search over the ways of one set row.
module sacl_way_sel
  import sacl_pkg::*;
(
  input  set_row_t            row_i,
  input  logic [NUM_WAYS-1:0] valid_i,
  input  logic [TAG_W-1:0]    tag_i,
  output lookup_t             lookup_o
);

  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic               any_free;
  logic [WAY_W-1:0]   free_way;
  logic [WAY_W-1:0]   old_way;
  logic [STAMP_W-1:0] old_stamp;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    any_free = 1'b0;
    free_way = '0;
    // scan downward so the lowest way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid_i[w] && (row_i[w].tag == tag_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid_i[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // oldest stamp, ties stay with the lower way
  always_comb begin
    old_way   = '0;
    old_stamp = row_i[0].stamp;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (row_i[w].stamp < old_stamp) begin
        old_way   = WAY_W'(w);
        old_stamp = row_i[w].stamp;
      end
    end
  end

  assign lookup_o.hit        = hit;
  assign lookup_o.hit_way    = hit_way;
  assign lookup_o.victim_way = any_free ? free_way : old_way;

endmodule

// File: src/set_assoc_cache_lru_controller_top.sv
`timescale 1ns / 1ps
// Top level of the set-associative cache tag and LRU controller.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  access  | in        | in_valid_i / in_ready_o | op_i, address_i, write_word_i
//  result  | out       | out_valid_o/out_ready_i | hit_o, way_o, fill_o, writeback_o,
//          |           |                         | writeback_address_o, bypass_o,
//          |           |                         | memory_write_o, memory_word_o
//  config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An access first reads the set row from the tag RAM, then matches, picks the victim,
// writes the row back (not on a bypass) and loads the result register.
// The tag RAM read data is registered, and accesses do not overlap.
// Reset clears valid bits, use counter and control state at once; no clearing pass.
// A full result register stalls the lookup cycle; a new access is taken as soon as
// the previous one has loaded its result, even while that result waits.
module set_assoc_cache_lru_controller_top
  import sacl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [WORD_W-1:0] write_word_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              hit_o,
  output logic [WAY_W-1:0]  way_o,
  output logic              fill_o,
  output logic              writeback_o,
  output logic [ADDR_W-1:0] writeback_address_o,
  output logic              bypass_o,
  output logic              memory_write_o,
  output logic [WORD_W-1:0] memory_word_o
);

  ctrl_state_e state_q, state_d;

  logic write_allocate_q, write_back_mode_q;

  logic                op_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [WORD_W-1:0]   word_q;
  logic [NUM_WAYS-1:0] valid_row_q;

  logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_q;
  logic [STAMP_W-1:0]                use_cnt_q;

  logic              out_valid_q;
  logic              hit_q, fill_q, wb_q, byp_q, mem_wr_q;
  logic [WAY_W-1:0]  way_q;
  logic [ADDR_W-1:0] wb_addr_q;
  logic [WORD_W-1:0] mem_word_q;

  logic in_fire, commit;
  logic [SET_W-1:0] in_set, set_r;
  logic [TAG_W-1:0] tag_r;

  logic [ROW_W-1:0] rdata, wdata;
  set_row_t         row, row_new;
  lookup_t          lk;

  logic              byp, fill, wb, mem_wr, do_write;
  logic [WAY_W-1:0]  sel_way;
  logic [ADDR_W-1:0] wb_addr;
  logic [STAMP_W-1:0] stamp_next;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_allocate_q  <= 1'b1;
      write_back_mode_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WRITE_ALLOCATE:  write_allocate_q  <= cfg_data_i;
        CFG_WRITE_BACK_MODE: write_back_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign commit     = (state_q == ST_LOOKUP) && (!out_valid_q || out_ready_i);

  assign in_set = (NUM_SETS > 1) ? SET_W'(address_i >> OFFS_W) : '0;
  assign set_r  = (NUM_SETS > 1) ? SET_W'(addr_q >> OFFS_W) : '0;
  assign tag_r  = addr_q[ADDR_W-1 -: TAG_W];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_LOOKUP;
      ST_LOOKUP: if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the transaction for the lookup cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= op_i;
      addr_q      <= address_i;
      word_q      <= write_word_i;
      valid_row_q <= valid_q[in_set];
    end
  end

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (set_r),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (in_set),
    .rdata_o (rdata)
  );

  assign row = set_row_t'(rdata);

  sacl_way_sel u_way_sel (
    .row_i    (row),
    .valid_i  (valid_row_q),
    .tag_i    (tag_r),
    .lookup_o (lk)
  );

  assign stamp_next = use_cnt_q + STAMP_W'(1);

  always_comb begin
    byp     = !lk.hit && op_q && !write_allocate_q;
    fill    = !lk.hit && !byp;
    sel_way = lk.hit ? lk.hit_way : lk.victim_way;
    wb      = fill && valid_row_q[sel_way] && row[sel_way].dirty;
    wb_addr = wb ? ADDR_W'({row[sel_way].tag, set_r, {OFFS_W{1'b0}}}) : '0;
    mem_wr  = byp || (op_q && !write_back_mode_q);
    row_new = row;
    if (fill) begin
      row_new[sel_way].tag   = tag_r;
      row_new[sel_way].dirty = 1'b0;
    end
    row_new[sel_way].stamp = stamp_next;
    if (op_q && write_back_mode_q) begin
      row_new[sel_way].dirty = 1'b1;
    end
  end

  assign do_write = commit && !byp;
  assign wdata    = ROW_W'(row_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      use_cnt_q <= '0;
    end else if (do_write) begin
      valid_q[set_r][sel_way] <= 1'b1;
      use_cnt_q               <= stamp_next;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q      <= lk.hit;
      way_q      <= byp ? '0 : sel_way;
      fill_q     <= fill;
      wb_q       <= wb;
      wb_addr_q  <= wb_addr;
      byp_q      <= byp;
      mem_wr_q   <= mem_wr;
      mem_word_q <= mem_wr ? word_q : '0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign hit_o               = hit_q;
  assign way_o               = way_q;
  assign fill_o              = fill_q;
  assign writeback_o         = wb_q;
  assign writeback_address_o = wb_addr_q;
  assign bypass_o            = byp_q;
  assign memory_write_o      = mem_wr_q;
  assign memory_word_o       = mem_word_q;

  a_bypass_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bypass_o) |-> (!hit_o && !fill_o && !writeback_o && way_o == '0))
    else $error("bypassed result carries cache activity");

  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && fill_o))
    else $error("hit and fill both set");

  a_wb_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && writeback_o) |-> fill_o)
    else $error("writeback without allocation");

  a_cnt_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> (use_cnt_q == $past(use_cnt_q) + STAMP_W'(1)))
    else $error("use counter did not advance on cached access");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("new transaction taken during lookup");

endmodule
